FILE: sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int FIELD_W          = 52;
    localparam int DEF_MAX_REGIONS  = 256;
    localparam int DEF_MAX_BLOCKS   = 256;
    localparam int DEF_PAGE_BITS    = 52;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_ZERO    = 3'd1,
        STS_NOSPACE = 3'd2,
        STS_FULL    = 3'd3,
        STS_UNKNOWN = 3'd4,
        STS_REGFULL = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RREQ,
        ST_RDAT,
        ST_CHECK,
        ST_BREQ,
        ST_BDAT,
        ST_FREQ,
        ST_FDAT,
        ST_SHREQ,
        ST_SHWR,
        ST_RESP
    } state_t;

endpackage

FILE: sv/ffpa_mem.sv
// ----------------------------------------------------------------------------
// ffpa_mem
// Simple dual-port table memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffpa_mem
    import ffpa_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_BLOCKS,
    parameter int WIDTH = 2 * DEF_PAGE_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Region and allocation tables in block memories, walked by one sequencer.
// ----------------------------------------------------------------------------
// Add region and clear: dispatch, then the result. Free: reads the block table
// entry by entry until the base matches, then shifts later entries down.
// Allocate: per region a read and a fit check, then a compare with each block
// for each candidate; the serial walk over the block memory read port sets
// the rate. One item in flight; a result waits in the output register.
// Reset (aresetn low, synchronous) empties both tables; no clearing pass.
module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_REGIONS = DEF_MAX_REGIONS,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // region_start_page, region_length_pages, request_pages, free_page
    input  logic [207:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, granted_page, released_pages, pages_in_use
    output logic [159:0] m_tdata
);

    localparam int PW  = PAGE_BITS;
    localparam int W   = PW + 2;
    localparam int RAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int BAW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int RCW = $clog2(MAX_REGIONS + 1);
    localparam int BCW = $clog2(MAX_BLOCKS + 1);
    localparam logic [W-1:0] LIMIT = W'(1) << PW;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [PW-1:0]      f0_reg, f0_next, f1_reg, f1_next;
    logic [PW-1:0]      len_reg, len_next, addr_reg, addr_next;
    logic [W-1:0]       cand_reg, cand_next, end_reg, end_next;
    logic [RCW-1:0]     rcnt_reg, rcnt_next, ridx_reg, ridx_next;
    logic [BCW-1:0]     bcnt_reg, bcnt_next, bidx_reg, bidx_next;
    logic [FIELD_W-1:0] used_reg, used_next;
    logic [PW-1:0]      rel_reg, rel_next, grant_reg, grant_next;
    status_t            sts_reg, sts_next;
    logic               mv_reg, mv_next;
    logic [159:0]       md_reg, md_next;

    logic            r_we, b_we;
    logic [RAW-1:0]  r_waddr, r_raddr;
    logic [BAW-1:0]  b_waddr, b_raddr;
    logic [2*PW-1:0] r_wdata, r_rdata, b_wdata, b_rdata;

    ffpa_mem #(.DEPTH(MAX_REGIONS), .WIDTH(2 * PW), .AW(RAW)) u_regions (
        .aclk(aclk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    ffpa_mem #(.DEPTH(MAX_BLOCKS), .WIDTH(2 * PW), .AW(BAW)) u_blocks (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    logic [W-1:0] rd_base, rd_size, rd_sum, bk_base, bk_end, cand_end;
    assign rd_base  = W'(r_rdata[PW-1:0]);
    assign rd_size  = W'(r_rdata[2*PW-1:PW]);
    assign rd_sum   = rd_base + rd_size;
    assign bk_base  = W'(b_rdata[PW-1:0]);
    assign bk_end   = bk_base + W'(b_rdata[2*PW-1:PW]);
    assign cand_end = cand_reg + W'(len_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= '0;
            bcnt_reg  <= '0;
            used_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            bcnt_reg  <= bcnt_next;
            used_reg  <= used_next;
            mv_reg    <= mv_next;
        end
        op_reg    <= op_next;
        f0_reg    <= f0_next;
        f1_reg    <= f1_next;
        len_reg   <= len_next;
        addr_reg  <= addr_next;
        cand_reg  <= cand_next;
        end_reg   <= end_next;
        ridx_reg  <= ridx_next;
        bidx_reg  <= bidx_next;
        rel_reg   <= rel_next;
        grant_reg <= grant_next;
        sts_reg   <= sts_next;
        md_reg    <= md_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        f0_next    = f0_reg;
        f1_next    = f1_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        cand_next  = cand_reg;
        end_next   = end_reg;
        rcnt_next  = rcnt_reg;
        ridx_next  = ridx_reg;
        bcnt_next  = bcnt_reg;
        bidx_next  = bidx_reg;
        used_next  = used_reg;
        rel_next   = rel_reg;
        grant_next = grant_reg;
        sts_next   = sts_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        r_we       = 1'b0;
        r_waddr    = rcnt_reg[RAW-1:0];
        r_wdata    = {f1_reg, f0_reg};
        r_raddr    = ridx_reg[RAW-1:0];
        b_we       = 1'b0;
        b_waddr    = bcnt_reg[BAW-1:0];
        b_wdata    = {len_reg, cand_reg[PW-1:0]};
        b_raddr    = bidx_reg[BAW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    f0_next    = s_tdata[PW-1:0];
                    f1_next    = s_tdata[52+PW-1:52];
                    len_next   = s_tdata[104+PW-1:104];
                    addr_next  = s_tdata[156+PW-1:156];
                    sts_next   = STS_OK;
                    rel_next   = '0;
                    grant_next = '0;
                    ridx_next  = '0;
                    bidx_next  = '0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (op_reg)
                    OP_ADD: begin
                        if (rcnt_reg == RCW'(MAX_REGIONS)) begin
                            sts_next = STS_REGFULL;
                        end else begin
                            r_we      = 1'b1;
                            rcnt_next = rcnt_reg + 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                    OP_ALLOC: begin
                        if (len_reg == '0) begin
                            sts_next   = STS_ZERO;
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_RREQ;
                        end
                    end
                    OP_FREE: state_next = ST_FREQ;
                    OP_CLEAR: begin
                        rcnt_next  = '0;
                        bcnt_next  = '0;
                        used_next  = '0;
                        state_next = ST_RESP;
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_RREQ: begin
                if (ridx_reg == rcnt_reg) begin
                    sts_next   = STS_NOSPACE;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_RDAT;
                end
            end
            ST_RDAT: begin
                cand_next  = rd_base;
                end_next   = (rd_sum > LIMIT) ? LIMIT : rd_sum;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (cand_end > end_reg) begin
                    ridx_next  = ridx_reg + 1'b1;
                    state_next = ST_RREQ;
                end else begin
                    bidx_next  = '0;
                    state_next = ST_BREQ;
                end
            end
            ST_BREQ: begin
                if (bidx_reg == bcnt_reg) begin
                    // no overlap: the candidate fits
                    if (bcnt_reg == BCW'(MAX_BLOCKS)) begin
                        sts_next = STS_FULL;
                    end else begin
                        b_we       = 1'b1;
                        bcnt_next  = bcnt_reg + 1'b1;
                        used_next  = used_reg + FIELD_W'(len_reg);
                        grant_next = cand_reg[PW-1:0];
                    end
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_BDAT;
                end
            end
            ST_BDAT: begin
                if (cand_reg < bk_end && bk_base < cand_end) begin
                    cand_next  = bk_end;
                    state_next = ST_CHECK;
                end else begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = ST_BREQ;
                end
            end
            ST_FREQ: begin
                if (bidx_reg == bcnt_reg) begin
                    sts_next   = STS_UNKNOWN;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_FDAT;
                end
            end
            ST_FDAT: begin
                if (b_rdata[PW-1:0] == addr_reg) begin
                    rel_next   = b_rdata[2*PW-1:PW];
                    state_next = ST_SHREQ;
                end else begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = ST_FREQ;
                end
            end
            ST_SHREQ: begin
                b_raddr = BAW'(bidx_reg + 1'b1);
                if (BCW'(bidx_reg + 1'b1) >= bcnt_reg) begin
                    bcnt_next  = bcnt_reg - 1'b1;
                    used_next  = used_reg - FIELD_W'(rel_reg);
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_SHWR;
                end
            end
            ST_SHWR: begin
                b_we       = 1'b1;
                b_waddr    = bidx_reg[BAW-1:0];
                b_wdata    = b_rdata;
                bidx_next  = bidx_reg + 1'b1;
                state_next = ST_SHREQ;
            end
            ST_RESP: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {1'b0, used_reg, FIELD_W'(rel_reg),
                                  FIELD_W'(grant_reg), sts_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_bcnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= BCW'(MAX_BLOCKS)) else $error("block count overflow");

    a_rcnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= RCW'(MAX_REGIONS)) else $error("region count overflow");

    a_bidx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BDAT || state_reg == ST_FDAT) |-> bidx_reg < bcnt_reg)
        else $error("block index past live count");

    a_used_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> $stable(used_reg))
        else $error("pages in use changed while idle");

endmodule

FILE: tb/sv/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker
// Watches both channels of the page allocator, keeps its own copy of the
// region and allocation tables, and compares every result with the forecast.
// ----------------------------------------------------------------------------
module ffpa_checker
    import ffpa_pkg::*;
#(
    parameter int MAX_REGIONS = DEF_MAX_REGIONS,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [207:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    output int           fail_count,
    output int           pending
);

    typedef logic [51:0] page_t;

    typedef struct packed {
        logic [2:0] status;
        page_t      granted;
        page_t      released;
        page_t      in_use;
    } grant_t;

    page_t  rgn_base [MAX_REGIONS];
    page_t  rgn_len  [MAX_REGIONS];
    int     rgn_cnt;
    page_t  blk_base [MAX_BLOCKS];
    page_t  blk_len  [MAX_BLOCKS];
    int     blk_cnt;
    page_t  used_pages;
    grant_t grant_q [$];

    function automatic logic [52:0] blk_end(int k);
        return {1'b0, blk_base[k]} + {1'b0, blk_len[k]};
    endfunction

    function automatic int overlap_at(logic [52:0] start, logic [52:0] len);
        for (int k = 0; k < blk_cnt; k++) begin
            if (start < blk_end(k) && {1'b0, blk_base[k]} < start + len)
                return k;
        end
        return -1;
    endfunction

    // First-fit search over regions in load order.
    function automatic bit place_search(page_t len, output page_t where);
        logic [52:0] cand, lim;
        int hit;
        where = '0;
        for (int r = 0; r < rgn_cnt; r++) begin
            cand = {1'b0, rgn_base[r]};
            lim  = {1'b0, rgn_base[r]} + {1'b0, rgn_len[r]};
            if (lim > 53'h10000000000000) lim = 53'h10000000000000;
            while (cand + len <= lim) begin
                hit = overlap_at(cand, {1'b0, len});
                if (hit < 0) begin
                    where = cand[51:0];
                    return 1;
                end
                cand = blk_end(hit);
            end
        end
        return 0;
    endfunction

    task automatic apply_item(op_t op, logic [207:0] d);
        grant_t g;
        page_t  where;
        int     k;
        g = '0;
        g.status = STS_OK;
        case (op)
            OP_ADD: begin
                if (rgn_cnt >= MAX_REGIONS) g.status = STS_REGFULL;
                else begin
                    rgn_base[rgn_cnt] = d[51:0];
                    rgn_len[rgn_cnt]  = d[103:52];
                    rgn_cnt++;
                end
            end
            OP_ALLOC: begin
                if (d[155:104] == 0) g.status = STS_ZERO;
                else if (!place_search(d[155:104], where)) g.status = STS_NOSPACE;
                else if (blk_cnt >= MAX_BLOCKS) g.status = STS_FULL;
                else begin
                    blk_base[blk_cnt] = where;
                    blk_len[blk_cnt]  = d[155:104];
                    blk_cnt++;
                    used_pages += d[155:104];
                    g.granted = where;
                end
            end
            OP_FREE: begin
                k = 0;
                while (k < blk_cnt && blk_base[k] != d[207:156]) k++;
                if (k >= blk_cnt) g.status = STS_UNKNOWN;
                else begin
                    g.released = blk_len[k];
                    for (; k + 1 < blk_cnt; k++) begin
                        blk_base[k] = blk_base[k + 1];
                        blk_len[k]  = blk_len[k + 1];
                    end
                    blk_cnt--;
                    used_pages -= g.released;
                end
            end
            default: begin
                rgn_cnt = 0;
                blk_cnt = 0;
                used_pages = '0;
            end
        endcase
        g.in_use = used_pages;
        grant_q.push_back(g);
    endtask

    assign pending = grant_q.size();

    always @(posedge aclk) begin
        grant_t want, got;
        if (!aresetn) begin
            rgn_cnt = 0;
            blk_cnt = 0;
            used_pages = '0;
            grant_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status   = m_tdata[2:0];
                got.granted  = m_tdata[54:3];
                got.released = m_tdata[106:55];
                got.in_use   = m_tdata[158:107];
                if (grant_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = grant_q.pop_front();
                    if (want != got) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp st=%0d g=%h r=%h u=%h got st=%0d g=%h r=%h u=%h",
                                want.status, want.granted, want.released, want.in_use,
                                got.status, got.granted, got.released, got.in_use);
                    end
                end
            end
            if (s_tvalid && s_tready) apply_item(op_t'(s_tuser), s_tdata);
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the page allocator: directed corner items, then random
// region/allocate/free/clear traffic with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import ffpa_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    int           fail_count;
    int           pending;
    logic [51:0]  granted_log [$];
    bit           stim_done = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    first_fit_page_allocator u_top (.*);

    ffpa_checker u_chk (.*);

    // Remember granted bases so frees mostly hit live allocations.
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready && m_tdata[2:0] == STS_OK && m_tdata[54:3] != 0)
            granted_log.push_back(m_tdata[54:3]);

    always begin
        @(negedge aclk);
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge aclk);
        m_tready <= 1'b1;
        @(posedge aclk);
        while (!m_tvalid) @(posedge aclk);
    end

    function automatic logic [51:0] rand52();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 52'({$urandom, $urandom} & 64'h000FFFFFFFFFFFFF);
            default: return 52'($urandom_range(0, 200));
        endcase
    endfunction

    // tvalid stays high between items unless a gap is drawn
    task automatic send(op_t op, logic [51:0] a, logic [51:0] b, logic [51:0] c,
                        logic [51:0] d, bit gap);
        int n;
        n = gap ? int'($urandom_range(0, 17)) : 0;
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {d, c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [51:0] pick;
        int idx;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        // directed
        send(OP_ALLOC, 0, 0, 5, 0, 0);             // no regions
        send(OP_ALLOC, 0, 0, 0, 0, 0);             // zero request
        send(OP_ADD, 100, 0, 0, 0, 0);             // zero-length region
        send(OP_ALLOC, 0, 0, 1, 0, 0);
        send(OP_ADD, 1000, 50, 0, 0, 0);
        send(OP_ALLOC, 0, 0, 20, 0, 1);
        send(OP_ALLOC, 0, 0, 20, 0, 1);
        send(OP_ALLOC, 0, 0, 20, 0, 1);            // no space
        send(OP_FREE, 0, 0, 0, 1000, 1);
        send(OP_ALLOC, 0, 0, 10, 0, 1);            // reuses the hole
        send(OP_FREE, 0, 0, 0, 1234, 1);           // unknown free
        send(OP_ADD, '1 - 10, '1, 0, 0, 1);        // clamp at page space end
        send(OP_ALLOC, 0, 0, 11, 0, 1);
        send(OP_ALLOC, 0, 0, 12, 0, 1);
        send(OP_ALLOC, 0, 0, '1, 0, 1);
        send(OP_FREE, 0, 0, 0, '1, 1);
        send(OP_CLEAR, '1, '1, '1, '1, 1);
        send(OP_ADD, 0, '1, 0, 0, 1);
        send(OP_ALLOC, 0, 0, '1, 0, 1);            // whole space
        send(OP_FREE, 0, 0, 0, 0, 1);
        // fill region table and block table
        for (int i = 0; i < 260; i++) send(OP_ADD, 52'(i * 4), 4, 0, 0, i < 3);
        for (int i = 0; i < 260; i++) send(OP_ALLOC, 0, 0, 52'(1 + (i & 1)), 0, 0);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);      // drain before random phase
        send(OP_CLEAR, 0, 0, 0, 0, 1);
        granted_log.delete();
        for (int i = 0; i < 40; i++) begin
            if (i == 20) begin
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            case ($urandom_range(0, 9))
                0, 1: send(OP_ADD, rand52(), rand52(), rand52(), rand52(), 1);
                2, 3, 4, 5: send(OP_ALLOC, rand52(), rand52(),
                                 $urandom_range(0, 3) == 0 ? rand52()
                                                           : 52'($urandom_range(1, 40)),
                                 rand52(), 1);
                6, 7, 8: begin
                    pick = rand52();
                    if (granted_log.size() != 0 && $urandom_range(0, 3) != 0) begin
                        idx = $urandom_range(0, granted_log.size() - 1);
                        pick = granted_log[idx];
                        granted_log.delete(idx);
                    end
                    send(OP_FREE, rand52(), rand52(), rand52(), pick, 1);
                end
                default: if ($urandom_range(0, 4) == 0) begin
                    send(OP_CLEAR, rand52(), rand52(), rand52(), rand52(), 1);
                    granted_log.delete();
                end else send(OP_ADD, 52'($urandom_range(0, 5000)),
                              52'($urandom_range(0, 300)), rand52(), rand52(), 1);
            endcase
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (2000) @(negedge aclk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
